### design/art_pkg.sv
// Shared types, codes and constants of the acknowledgement retransmit tracker.
`default_nettype none
package art_pkg;

    localparam int unsigned DEPTH_DEF        = 16;
    localparam int unsigned CMD_CODE_DEF     = 2;
    localparam int unsigned CMD_LOW_CODE_DEF = 3;

    localparam logic [1:0] OP_SEND = 2'd0;
    localparam logic [1:0] OP_ACK  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [2:0] K_STORED   = 3'd0;
    localparam logic [2:0] K_IGNORED  = 3'd1;
    localparam logic [2:0] K_FULL     = 3'd2;
    localparam logic [2:0] K_ACK_OK   = 3'd3;
    localparam logic [2:0] K_ACK_MISS = 3'd4;
    localparam logic [2:0] K_RESEND   = 3'd5;
    localparam logic [2:0] K_DONE     = 3'd6;

    localparam logic [1:0] REG_ALPHA = 2'd0;
    localparam logic [1:0] REG_BETA  = 2'd1;
    localparam logic [1:0] REG_INIT  = 2'd2;

    localparam logic [7:0]  ALPHA_RST      = 8'd32;
    localparam logic [7:0]  BETA_RST       = 8'd64;
    localparam logic [15:0] INIT_RST       = 16'd1000;
    localparam logic [23:0] MIN_RTO_Q3     = 24'd1600;
    localparam logic [23:0] MAX_Q3         = 24'hFFFFFF;
    localparam logic [19:0] T_MAX          = 20'hFFFFF;
    localparam logic [19:0] RESEND_CAP_MS  = 20'd1500;
    localparam logic [7:0]  GIVEUP_RESENDS = 8'd15;
    localparam logic [32:0] GIVEUP_AGE_MS  = 33'd15000;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] time_ms;
        logic [3:0]  pkt_type;
        logic [15:0] pkt_id;
        logic        needs_ack;
        logic [7:0]  buffer_tag;
        logic        ack_is_low;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic        tick_failed;
        logic [15:0] out_pkt_id;
        logic [3:0]  out_pkt_type;
        logic [7:0]  out_buffer_tag;
        logic [31:0] next_deadline_ms;
        logic [19:0] timeout_ms;
        logic        last;
    } t_out_item;

    typedef enum logic [4:0] {
        CMD_NONE, CMD_LOAD, CMD_INSERT, CMD_ACK_SCAN, CMD_ACK_APPLY,
        CMD_EST0, CMD_EST1, CMD_EST2, CMD_EST3, CMD_EST4, CMD_EST5, CMD_EST6,
        CMD_EST_FIRST, CMD_TICK_SCAN, CMD_MIN_CLR, CMD_MIN_STEP,
        CMD_REP_CLR, CMD_REP_STEP, CMD_EMIT
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       send_store;
        logic       at_end;
        logic       match;
        logic       will_est;
        logic       have;
        logic       queued;
        logic       giveup;
    } t_dp_status;

endpackage
`default_nettype wire

### design/art_ctrl.sv
// Sequencing state machine of the retransmit tracker.
`default_nettype none
module art_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  art_pkg::t_dp_status i_st,
    output art_pkg::t_cmd       o_cmd,
    output logic                o_busy
);
    import art_pkg::*;

    typedef enum logic [17:0] {
        S_IDLE      = 18'd1 << 0,
        S_DISPATCH  = 18'd1 << 1,
        S_ACK_SCAN  = 18'd1 << 2,
        S_ACK_APPLY = 18'd1 << 3,
        S_EST0      = 18'd1 << 4,
        S_EST1      = 18'd1 << 5,
        S_EST2      = 18'd1 << 6,
        S_EST3      = 18'd1 << 7,
        S_EST4      = 18'd1 << 8,
        S_EST5      = 18'd1 << 9,
        S_EST6      = 18'd1 << 10,
        S_EST_FIRST = 18'd1 << 11,
        S_TICK_SCAN = 18'd1 << 12,
        S_MIN_CLR   = 18'd1 << 13,
        S_MIN       = 18'd1 << 14,
        S_REP_CLR   = 18'd1 << 15,
        S_REP       = 18'd1 << 16,
        S_EMIT      = 18'd1 << 17
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd   = CMD_LOAD;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_st.op)
                    OP_SEND: begin
                        if (i_st.send_store) o_cmd = CMD_INSERT;
                        n_state = S_MIN_CLR;
                    end
                    OP_ACK:  n_state = S_ACK_SCAN;
                    OP_TICK: n_state = S_TICK_SCAN;
                    default: n_state = S_MIN_CLR;
                endcase
            end
            S_ACK_SCAN: begin
                o_cmd = CMD_ACK_SCAN;
                if (i_st.at_end) n_state = S_MIN_CLR;
                else if (i_st.match) n_state = S_ACK_APPLY;
            end
            S_ACK_APPLY: begin
                o_cmd   = CMD_ACK_APPLY;
                n_state = i_st.will_est ? S_EST0 : S_MIN_CLR;
            end
            S_EST0: begin
                o_cmd   = CMD_EST0;
                n_state = i_st.have ? S_EST1 : S_EST_FIRST;
            end
            S_EST1: begin
                o_cmd   = CMD_EST1;
                n_state = S_EST2;
            end
            S_EST2: begin
                o_cmd   = CMD_EST2;
                n_state = S_EST3;
            end
            S_EST3: begin
                o_cmd   = CMD_EST3;
                n_state = S_EST4;
            end
            S_EST4: begin
                o_cmd   = CMD_EST4;
                n_state = S_EST5;
            end
            S_EST5: begin
                o_cmd   = CMD_EST5;
                n_state = S_EST6;
            end
            S_EST6: begin
                o_cmd   = CMD_EST6;
                n_state = S_MIN_CLR;
            end
            S_EST_FIRST: begin
                o_cmd   = CMD_EST_FIRST;
                n_state = S_MIN_CLR;
            end
            S_TICK_SCAN: begin
                if (i_st.at_end) n_state = S_MIN_CLR;
                else o_cmd = CMD_TICK_SCAN;
            end
            S_MIN_CLR: begin
                o_cmd   = CMD_MIN_CLR;
                n_state = S_MIN;
            end
            S_MIN: begin
                if (i_st.at_end) n_state = (i_st.op == OP_TICK) ? S_REP_CLR : S_EMIT;
                else o_cmd = CMD_MIN_STEP;
            end
            S_REP_CLR: begin
                o_cmd   = CMD_REP_CLR;
                n_state = S_REP;
            end
            S_REP: begin
                if (i_st.at_end) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd = CMD_REP_STEP;
                    if (i_st.queued && i_st.giveup) n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                o_cmd   = CMD_EMIT;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

### design/art_dp.sv
// Slot table, round-trip estimator and result register of the retransmit tracker.
`default_nettype none
module art_dp #(
    parameter int unsigned DEPTH            = art_pkg::DEPTH_DEF,
    parameter int unsigned COMMAND_CODE     = art_pkg::CMD_CODE_DEF,
    parameter int unsigned COMMAND_LOW_CODE = art_pkg::CMD_LOW_CODE_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  art_pkg::t_cmd       i_cmd,
    input  art_pkg::t_in_item   i_item,
    input  wire                 i_cfg_we,
    input  wire  [1:0]          i_cfg_index,
    input  wire  [15:0]         i_cfg_data,
    output art_pkg::t_dp_status o_st,
    output art_pkg::t_out_item  o_result,
    output logic                o_strobe
);
    import art_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [3:0]  r_type   [DEPTH];
    logic [15:0] r_id     [DEPTH];
    logic [7:0]  r_tag    [DEPTH];
    logic [31:0] r_first  [DEPTH];
    logic [31:0] r_due    [DEPTH];
    logic [7:0]  r_resends[DEPTH];
    logic [7:0]  r_sends  [DEPTH];
    logic        r_acked  [DEPTH];
    logic        r_queued [DEPTH];

    logic [CW-1:0] r_n, r_idx;
    t_in_item      r_in;
    logic [2:0]    r_kind;
    logic [15:0]   r_oid;
    logic [3:0]    r_otype;
    logic [7:0]    r_otag;
    logic [31:0]   r_earliest;
    logic [31:0]   r_rsample;
    logic [23:0]   r_srtt, r_var, r_rto, r_r8, r_diff;
    logic [33:0]   r_acc;
    logic          r_have;
    logic [7:0]    r_alpha, r_beta;
    logic          r_strobe;
    t_out_item     r_out;

    logic [IW-1:0] w_ix;
    logic [21:0]   w_tceil;
    logic [19:0]   w_t, w_step;
    logic [23:0]   w_margin;
    logic [3:0]    w_target;
    logic [32:0]   w_sum_send, w_sum_tick;
    logic [31:0]   w_due_send, w_due_tick;
    logic          w_full, w_at_end, w_match, w_drop, w_hit, w_giveup;
    logic [7:0]    w_sends_dec;
    logic [8:0]    w_mul_a;
    logic [23:0]   w_mul_b;
    logic [32:0]   w_prod;
    logic [23:0]   w_r8;
    logic [26:0]   w_sum_first, w_sum_late;

    assign w_ix       = r_idx[IW-1:0];
    assign w_tceil    = 22'((25'(r_rto) + 25'd7) >> 3);
    assign w_t        = (w_tceil > 22'(T_MAX)) ? T_MAX : w_tceil[19:0];
    assign w_step     = (w_t > RESEND_CAP_MS) ? RESEND_CAP_MS : w_t;
    assign w_margin   = 24'((25'(r_rto) + 25'd1) >> 1);
    assign w_target   = r_in.ack_is_low ? 4'(COMMAND_LOW_CODE) : 4'(COMMAND_CODE);
    assign w_sum_send = {1'b0, r_in.time_ms} + 33'(w_t);
    assign w_due_send = w_sum_send[32] ? '1 : w_sum_send[31:0];
    assign w_sum_tick = {1'b0, r_in.time_ms} + 33'(w_step);
    assign w_due_tick = w_sum_tick[32] ? '1 : w_sum_tick[31:0];
    assign w_full     = (r_n == CW'(DEPTH));
    assign w_at_end   = (r_idx == r_n);
    assign w_match    = (r_type[w_ix] == w_target) && (r_id[w_ix] == r_in.pkt_id);
    assign w_drop     = r_acked[w_ix]
                        && ((33'(r_due[w_ix]) + 33'(w_margin)) <= 33'(r_in.time_ms));
    assign w_hit      = !r_acked[w_ix] && (r_due[w_ix] <= r_in.time_ms);
    assign w_giveup   = (r_resends[w_ix] > GIVEUP_RESENDS)
                        && ((33'(r_first[w_ix]) + GIVEUP_AGE_MS) < 33'(r_in.time_ms));
    assign w_sends_dec = (r_sends[w_ix] == 8'd0) ? 8'd0 : r_sends[w_ix] - 8'd1;
    assign w_r8       = (r_rsample[31:21] != 11'd0) ? MAX_Q3 : {r_rsample[20:0], 3'b000};
    assign w_sum_first = 27'(r_r8) + (27'(r_r8[23:1]) << 2);
    assign w_sum_late  = 27'(r_srtt) + (27'(r_var) << 2);

    always_comb begin
        w_mul_a = 9'd0;
        w_mul_b = 24'd0;
        case (i_cmd)
            CMD_EST1: begin
                w_mul_a = 9'd256 - 9'(r_beta);
                w_mul_b = r_var;
            end
            CMD_EST2: begin
                w_mul_a = 9'(r_beta);
                w_mul_b = r_diff;
            end
            CMD_EST3: begin
                w_mul_a = 9'd256 - 9'(r_alpha);
                w_mul_b = r_srtt;
            end
            CMD_EST4: begin
                w_mul_a = 9'(r_alpha);
                w_mul_b = r_r8;
            end
            default: begin
                w_mul_a = 9'd0;
                w_mul_b = 24'd0;
            end
        endcase
    end
    assign w_prod = 33'(w_mul_a) * 33'(w_mul_b);

    // slot payload
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_LOAD: begin
                for (int j = 0; j < DEPTH; j++) r_queued[j] <= 1'b0;
            end
            CMD_INSERT: begin
                for (int j = DEPTH - 1; j > 0; j--) begin
                    r_type[j]    <= r_type[j-1];
                    r_id[j]      <= r_id[j-1];
                    r_tag[j]     <= r_tag[j-1];
                    r_first[j]   <= r_first[j-1];
                    r_due[j]     <= r_due[j-1];
                    r_resends[j] <= r_resends[j-1];
                    r_sends[j]   <= r_sends[j-1];
                    r_acked[j]   <= r_acked[j-1];
                    r_queued[j]  <= r_queued[j-1];
                end
                r_type[0]    <= r_in.pkt_type;
                r_id[0]      <= r_in.pkt_id;
                r_tag[0]     <= r_in.buffer_tag;
                r_first[0]   <= r_in.time_ms;
                r_due[0]     <= w_due_send;
                r_resends[0] <= 8'd0;
                r_sends[0]   <= 8'd1;
                r_acked[0]   <= 1'b0;
                r_queued[0]  <= 1'b0;
            end
            CMD_ACK_APPLY, CMD_TICK_SCAN: begin
                if ((i_cmd == CMD_ACK_APPLY && w_sends_dec == 8'd0)
                    || (i_cmd == CMD_TICK_SCAN && w_drop)) begin
                    for (int j = 0; j < DEPTH - 1; j++) begin
                        if (IW'(j) >= w_ix) begin
                            r_type[j]    <= r_type[j+1];
                            r_id[j]      <= r_id[j+1];
                            r_tag[j]     <= r_tag[j+1];
                            r_first[j]   <= r_first[j+1];
                            r_due[j]     <= r_due[j+1];
                            r_resends[j] <= r_resends[j+1];
                            r_sends[j]   <= r_sends[j+1];
                            r_acked[j]   <= r_acked[j+1];
                            r_queued[j]  <= r_queued[j+1];
                        end
                    end
                end else if (i_cmd == CMD_ACK_APPLY) begin
                    r_sends[w_ix] <= w_sends_dec;
                    r_acked[w_ix] <= 1'b1;
                end else if (w_hit && !w_at_end) begin
                    r_due[w_ix]    <= w_due_tick;
                    r_queued[w_ix] <= 1'b1;
                    if (r_resends[w_ix] != 8'hFF) r_resends[w_ix] <= r_resends[w_ix] + 8'd1;
                    if (r_sends[w_ix] != 8'hFF) r_sends[w_ix] <= r_sends[w_ix] + 8'd1;
                end
            end
            default: begin
            end
        endcase
    end

    // item, result fields and scan bookkeeping
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_LOAD: begin
                r_in      <= i_item;
                r_oid     <= 16'd0;
                r_otype   <= 4'd0;
                r_otag    <= 8'd0;
                case (i_item.operation)
                    OP_SEND: begin
                        r_kind  <= !i_item.needs_ack ? K_IGNORED : (w_full ? K_FULL : K_STORED);
                        r_oid   <= i_item.pkt_id;
                        r_otype <= i_item.pkt_type;
                        r_otag  <= i_item.buffer_tag;
                    end
                    OP_ACK: begin
                        r_kind  <= K_ACK_MISS;
                        r_oid   <= i_item.pkt_id;
                        r_otype <= i_item.ack_is_low ? 4'(COMMAND_LOW_CODE) : 4'(COMMAND_CODE);
                    end
                    OP_TICK: r_kind <= K_DONE;
                    default: r_kind <= K_IGNORED;
                endcase
            end
            CMD_ACK_APPLY: begin
                r_kind    <= K_ACK_OK;
                r_oid     <= r_id[w_ix];
                r_otype   <= r_type[w_ix];
                r_otag    <= r_tag[w_ix];
                r_rsample <= r_in.time_ms - r_first[w_ix];
            end
            CMD_MIN_CLR: r_earliest <= '1;
            CMD_MIN_STEP: begin
                if (!r_acked[w_ix] && r_due[w_ix] < r_earliest) r_earliest <= r_due[w_ix];
            end
            default: begin
            end
        endcase
    end

    // control counters, estimator, configuration, result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n      <= '0;
            r_idx    <= '0;
            r_srtt   <= '0;
            r_var    <= '0;
            r_rto    <= 24'(INIT_RST) << 3;
            r_have   <= 1'b0;
            r_alpha  <= ALPHA_RST;
            r_beta   <= BETA_RST;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_ALPHA: r_alpha <= i_cfg_data[7:0];
                    REG_BETA:  r_beta  <= i_cfg_data[7:0];
                    REG_INIT: begin
                        if (!r_have) r_rto <= 24'(i_cfg_data) << 3;
                    end
                    default: begin
                    end
                endcase
            end
            case (i_cmd)
                CMD_LOAD, CMD_MIN_CLR, CMD_REP_CLR: r_idx <= '0;
                CMD_INSERT: r_n <= r_n + CW'(1);
                CMD_ACK_SCAN: begin
                    if (!w_at_end && !w_match) r_idx <= r_idx + CW'(1);
                end
                CMD_ACK_APPLY: begin
                    if (w_sends_dec == 8'd0) r_n <= r_n - CW'(1);
                end
                CMD_TICK_SCAN: begin
                    if (w_drop) r_n <= r_n - CW'(1);
                    else r_idx <= r_idx + CW'(1);
                end
                CMD_MIN_STEP: r_idx <= r_idx + CW'(1);
                CMD_REP_STEP: begin
                    r_idx <= r_idx + CW'(1);
                    if (r_queued[w_ix]) begin
                        r_strobe <= 1'b1;
                        r_out    <= '{kind: w_giveup ? K_DONE : K_RESEND,
                                      tick_failed: w_giveup,
                                      out_pkt_id: r_id[w_ix],
                                      out_pkt_type: r_type[w_ix],
                                      out_buffer_tag: r_tag[w_ix],
                                      next_deadline_ms: r_earliest,
                                      timeout_ms: w_t,
                                      last: w_giveup};
                    end
                end
                CMD_EMIT: begin
                    r_strobe <= 1'b1;
                    r_out    <= '{kind: r_kind, tick_failed: 1'b0,
                                  out_pkt_id: r_oid, out_pkt_type: r_otype,
                                  out_buffer_tag: r_otag, next_deadline_ms: r_earliest,
                                  timeout_ms: w_t, last: 1'b1};
                end
                CMD_EST0: begin
                    r_r8   <= w_r8;
                    r_diff <= (r_srtt > w_r8) ? r_srtt - w_r8 : w_r8 - r_srtt;
                end
                CMD_EST1: r_acc <= 34'(w_prod);
                CMD_EST2: r_acc <= r_acc + 34'(w_prod);
                CMD_EST3: begin
                    r_var <= 24'((r_acc + 34'd128) >> 8);
                    r_acc <= 34'(w_prod);
                end
                CMD_EST4: r_acc <= r_acc + 34'(w_prod);
                CMD_EST5: r_srtt <= 24'((r_acc + 34'd128) >> 8);
                CMD_EST6: begin
                    if (w_sum_late < 27'(MIN_RTO_Q3)) r_rto <= MIN_RTO_Q3;
                    else if (w_sum_late > 27'(MAX_Q3)) r_rto <= MAX_Q3;
                    else r_rto <= w_sum_late[23:0];
                end
                CMD_EST_FIRST: begin
                    r_srtt <= r_r8;
                    r_var  <= {1'b0, r_r8[23:1]};
                    r_have <= 1'b1;
                    r_rto  <= (w_sum_first > 27'(MAX_Q3)) ? MAX_Q3 : w_sum_first[23:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_st = '{op: r_in.operation,
                    send_store: r_in.needs_ack && !w_full,
                    at_end: w_at_end,
                    match: w_match,
                    will_est: (w_sends_dec == 8'd0) && (r_resends[w_ix] == 8'd0),
                    have: r_have,
                    queued: r_queued[w_ix],
                    giveup: w_giveup};
    assign o_result = r_out;
    assign o_strobe = r_strobe;

endmodule
`default_nettype wire

### design/ack_retransmit_tracker_top.sv
// Top level of the acknowledgement retransmit tracker.
// Each request scans the occupied slots one at a time before its last result is strobed.
// Throughput: one request at a time; busy falls while the last result is strobed.
// Results are strobed for one cycle each; the receiver cannot stall.
// Synchronous active-low reset empties the table and loads configuration defaults.
`default_nettype none
module ack_retransmit_tracker_top #(
    parameter int unsigned DEPTH            = art_pkg::DEPTH_DEF,
    parameter int unsigned COMMAND_CODE     = art_pkg::CMD_CODE_DEF,
    parameter int unsigned COMMAND_LOW_CODE = art_pkg::CMD_LOW_CODE_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    output logic               busy,
    input  art_pkg::t_in_item  i_item,
    output art_pkg::t_out_item o_result,
    output logic               o_strobe,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire  [1:0]         i_cfg_index,
    input  wire  [15:0]        i_cfg_data
);
    import art_pkg::*;

    t_cmd       w_cmd;
    t_dp_status w_st;

    assign o_cfg_ready = 1'b1;

    art_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_st    (w_st),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    art_dp #(
        .DEPTH            (DEPTH),
        .COMMAND_CODE     (COMMAND_CODE),
        .COMMAND_LOW_CODE (COMMAND_LOW_CODE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_st        (w_st),
        .o_result    (o_result),
        .o_strobe    (o_strobe)
    );

endmodule
`default_nettype wire
